>>> hdl/woc_pkg.sv
// Package for the word occurrence counter: sizes, request codes and the
// item record that travels along the row of slot cells.
// No dependencies.
package woc_pkg;

	localparam int SLOTS          = 128;
	localparam int WORD_CHARS     = 9;
	localparam int MAX_TEXT_WORDS = 128;

	localparam int STRIDE = WORD_CHARS + 1;
	localparam int LEN_W  = $clog2(STRIDE);
	localparam int CELL_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_W  = (CELL_W > 7) ? CELL_W : 7;
	localparam int CMP_W  = (IDX_W > 8) ? IDX_W : 8;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_TEXT  = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]                  req_type;
		logic [6:0]                  slot;
		logic [3:0]                  position;
		logic [7:0]                  char_value;
		logic                        hit;
		logic [WORD_CHARS-1:0][7:0]  word;
		logic [LEN_W-1:0]            word_len;
		logic [7:0]                  match_count;
		logic [7:0]                  words_seen;
	} stage_t;

endpackage

>>> hdl/woc_if.sv
// Request and result channel interfaces of the word occurrence counter.
// No dependencies.
interface woc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [6:0] slot;
	logic [3:0] position;
	logic [7:0] char_value;
	logic       text_last;

	modport source (output valid, req_type, slot, position, char_value, text_last,
		input ready);
	modport sink (input valid, req_type, slot, position, char_value, text_last,
		output ready);
endinterface

interface woc_res_if;
	logic       valid;
	logic       ready;
	logic [6:0] slot_out;
	logic [7:0] match_count;
	logic [7:0] words_seen;

	modport source (output valid, slot_out, match_count, words_seen, input ready);
	modport sink (input valid, slot_out, match_count, words_seen, output ready);
endinterface

>>> hdl/woc_front.sv
// Text front end: letter detection, word buffer, word end and word total.
// Builds the item record that enters the cell row. Depends on woc_pkg.
module woc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [1:0]     req_type,
	input  logic [6:0]     slot,
	input  logic [3:0]     position,
	input  logic [7:0]     char_value,
	input  logic           text_last,
	output woc_pkg::stage_t entry
);
	import woc_pkg::*;

	logic [WORD_CHARS-1:0][7:0] wbuf_q, wbuf_n;
	logic [LEN_W-1:0]           len_q, len_app, len_n;
	logic                       inword_q, inword_n;
	logic [7:0]                 total_q, total_n;
	logic                       letter, ends, counts;

	always_comb begin
		letter = (char_value >= 8'h41 && char_value <= 8'h5A) ||
			(char_value >= 8'h61 && char_value <= 8'h7A);
		wbuf_n   = wbuf_q;
		len_app  = len_q;
		len_n    = len_q;
		inword_n = inword_q;
		total_n  = total_q;
		ends     = 1'b0;
		counts   = 1'b0;
		case (req_type)
			REQ_START: begin
				len_n    = '0;
				inword_n = 1'b0;
				total_n  = '0;
			end
			REQ_TEXT: begin
				if (letter) begin
					for (int k = 0; k < WORD_CHARS; k++) begin
						if (LEN_W'(k) == len_q)
							wbuf_n[k] = char_value;
					end
					if (len_q < LEN_W'(WORD_CHARS))
						len_app = len_q + LEN_W'(1);
					ends = text_last;
				end else begin
					ends = inword_q;
				end
				len_n = len_app;
				if (ends) begin
					counts = total_q < 8'(MAX_TEXT_WORDS);
					if (counts)
						total_n = total_q + 8'd1;
					len_n    = '0;
					inword_n = 1'b0;
				end else begin
					inword_n = inword_q | letter;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		entry.req_type    = req_type;
		entry.slot        = slot;
		entry.position    = position;
		entry.char_value  = char_value;
		entry.hit         = counts;
		entry.word        = wbuf_n;
		entry.word_len    = len_app;
		entry.match_count = '0;
		entry.words_seen  = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			inword_q <= 1'b0;
			total_q  <= '0;
		end else if (take) begin
			len_q    <= len_n;
			inword_q <= inword_n;
			total_q  <= total_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			wbuf_q <= wbuf_n;
	end

endmodule

>>> hdl/woc_cell.sv
// One query slot: stored query word, occurrence count and one stage of the
// item row. Each item is acted on as it passes. Depends on woc_pkg.
module woc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [woc_pkg::IDX_W-1:0]   cell_idx,
	input  logic [7:0]                  query_count,
	input  logic                        d_valid,
	input  woc_pkg::stage_t             d,
	output logic                        q_valid,
	output woc_pkg::stage_t             q
);
	import woc_pkg::*;

	logic [STRIDE-1:0][7:0] chars_q;
	logic [7:0]             count_q;
	logic                   valid_q;
	stage_t                 stg_q;
	stage_t                 passed;
	logic                   here, active, eq_all, match, fire;

	always_comb begin
		here   = IDX_W'(d.slot) == cell_idx;
		active = CMP_W'(cell_idx) < CMP_W'(query_count);
		fire   = adv && d_valid;
		eq_all = 1'b1;
		for (int k = 0; k < WORD_CHARS; k++) begin
			if (LEN_W'(k) < d.word_len && chars_q[k] != d.word[k])
				eq_all = 1'b0;
		end
		match  = (chars_q[0] != 8'd0) && eq_all && (chars_q[d.word_len] == 8'd0);
		passed = d;
		if (d.req_type == REQ_READ && here)
			passed.match_count = count_q;
	end

	// empty slots after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
		end else if (fire && d.req_type == REQ_LOAD && here) begin
			for (int k = 0; k < STRIDE; k++) begin
				if (32'(d.position) == k)
					chars_q[k] <= d.char_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			case (d.req_type)
				REQ_START: count_q <= '0;
				REQ_TEXT: begin
					if (d.hit && active && match && count_q != COUNT_MAX)
						count_q <= count_q + 8'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			stg_q <= passed;
	end

	assign q_valid = valid_q;
	assign q       = stg_q;

endmodule

>>> hdl/word_occurrence_counter.sv
// Word occurrence counter: a row of SLOTS cells, one per query slot, through
// which every request item travels one cell per clock while the row advances.
// The accepting edge places an item in the first cell's stage, and the last
// cell's stage is the result register. One item is accepted each clock unless
// the row is stalled. A held result stalls the whole row and the request side
// with it. No clearing pass is needed after reset. query_count may only be
// written while no item is in flight. Depends on woc_pkg, woc_if, woc_front
// and woc_cell.
module word_occurrence_counter (
	input  logic       clk,
	input  logic       arst_n,
	woc_req_if.sink    req,
	woc_res_if.source  res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data
);
	import woc_pkg::*;

	logic [7:0]   query_count_q;
	logic         adv;
	logic [SLOTS:0] v;
	stage_t       p [SLOTS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			query_count_q <= '0;
		else if (cfg_we)
			query_count_q <= cfg_data;
	end

	assign adv       = !v[SLOTS] || res.ready;
	assign req.ready = adv;
	assign v[0]      = req.valid;

	woc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (req.valid && adv),
		.req_type   (req.req_type),
		.slot       (req.slot),
		.position   (req.position),
		.char_value (req.char_value),
		.text_last  (req.text_last),
		.entry      (p[0])
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		woc_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.cell_idx    (IDX_W'(i)),
			.query_count (query_count_q),
			.d_valid     (v[i]),
			.d           (p[i]),
			.q_valid     (v[i+1]),
			.q           (p[i+1])
		);
	end

	assign res.valid       = v[SLOTS];
	assign res.slot_out    = p[SLOTS].slot;
	assign res.match_count = p[SLOTS].match_count;
	assign res.words_seen  = p[SLOTS].words_seen;

endmodule

>>> hdl/woc_checker.sv
// Port checker for word_occurrence_counter, attached by bind.
// Depends on woc_pkg and the top level's ports.
module woc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [6:0] res_slot_out,
	input logic [7:0] res_match_count,
	input logic [7:0] res_words_seen
);
	import woc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_slot_out) &&
			$stable(res_match_count) && $stable(res_words_seen))
		else $error("result changed while stalled");

	a_row_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!res_valid || res_ready))
		else $error("request side not tied to row advance");

	a_words_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_words_seen <= 8'(MAX_TEXT_WORDS))
		else $error("word total above limit");

endmodule

bind word_occurrence_counter woc_checker u_woc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_slot_out    (res.slot_out),
	.res_match_count (res.match_count),
	.res_words_seen  (res.words_seen)
);

>>> test/word_occurrence_counter_checker.sv
`timescale 1ns / 100ps
// Checker for the word occurrence counter: keeps its own copy of the query table
// and text word state, predicts one result per request item and checks them in order.
// Depends on woc_pkg and woc_if.
module word_occurrence_counter_checker
	import woc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	woc_req_if         req,
	woc_res_if         res,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output int         pending,
	output int         errors
);

	typedef struct packed {
		logic [6:0] slot;
		logic [7:0] count;
		logic [7:0] words;
	} tally_t;

	logic [7:0]  query_tab [SLOTS][STRIDE];
	logic [7:0]  hits [SLOTS];
	logic [7:0]  word_buf [WORD_CHARS];
	int unsigned word_len;
	bit          in_word;
	int unsigned word_total;
	logic [7:0]  query_limit;
	tally_t      tally_q [$];
	int          fails = 0;

	assign errors = fails;

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic bit slot_hit(input int s);
		if (query_tab[s][0] == 8'd0)
			return 1'b0;
		for (int k = 0; k < word_len; k++)
			if (query_tab[s][k] != word_buf[k])
				return 1'b0;
		return query_tab[s][word_len] == 8'd0;
	endfunction

	function automatic void clear_word();
		foreach (word_buf[k])
			word_buf[k] = 8'd0;
		word_len = 0;
		in_word = 1'b0;
	endfunction

	function automatic void close_word();
		int lim;
		if (!in_word)
			return;
		if (word_total < MAX_TEXT_WORDS) begin
			word_total++;
			lim = (query_limit > SLOTS) ? SLOTS : query_limit;
			for (int s = 0; s < lim; s++)
				if (slot_hit(s) && hits[s] != COUNT_MAX)
					hits[s]++;
		end
		clear_word();
	endfunction

	function automatic void start_text();
		foreach (hits[s])
			hits[s] = 8'd0;
		clear_word();
		word_total = 0;
	endfunction

	function automatic tally_t tally_item(input logic [1:0] kind, input logic [6:0] slot,
		input logic [3:0] pos, input logic [7:0] ch, input logic last);
		tally_t t;
		t.count = 8'd0;
		case (kind)
			REQ_LOAD: begin
				if (slot < SLOTS && pos <= WORD_CHARS)
					query_tab[slot][pos] = ch;
			end
			REQ_START: begin
				start_text();
			end
			REQ_TEXT: begin
				if (is_letter(ch)) begin
					if (word_len < WORD_CHARS) begin
						word_buf[word_len] = ch;
						word_len++;
					end
					in_word = 1'b1;
				end else begin
					close_word();
				end
				if (last)
					close_word();
			end
			REQ_READ: begin
				if (slot < SLOTS)
					t.count = hits[slot];
			end
			default: ;
		endcase
		t.slot = slot;
		t.words = 8'(word_total);
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tally_t want;
		if (!arst_n) begin
			foreach (query_tab[s, k])
				query_tab[s][k] = 8'd0;
			query_limit = 8'd0;
			start_text();
			tally_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				query_limit = cfg_data;
			if (req.valid && req.ready)
				tally_q.push_back(tally_item(req.req_type, req.slot, req.position,
					req.char_value, req.text_last));
			if (res.valid && res.ready) begin
				if (tally_q.size() == 0) begin
					$error("result with none expected: slot_out %0d", res.slot_out);
					fails++;
				end else begin
					want = tally_q.pop_front();
					if (res.slot_out !== want.slot) begin
						$error("slot_out: expected %0d, got %0d", want.slot, res.slot_out);
						fails++;
					end
					if (res.match_count !== want.count) begin
						$error("match_count: expected %0d, got %0d", want.count,
							res.match_count);
						fails++;
					end
					if (res.words_seen !== want.words) begin
						$error("words_seen: expected %0d, got %0d", want.words,
							res.words_seen);
						fails++;
					end
				end
			end
			pending <= tally_q.size();
		end
	end

endmodule

>>> test/word_occurrence_counter_test.sv
`timescale 1ns / 100ps
// Testbench top for the word occurrence counter: clock, reset, query_count writes,
// request stimulus and result back-pressure; checking sits in the checker module.
// Depends on woc_pkg, woc_if, word_occurrence_counter and its checker.
module word_occurrence_counter_test;
	import woc_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CALM_ITEMS   = 200;
	localparam int IDLE_LIMIT   = 4000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_data;
	int         pending;
	int         errors;
	int         sent = 0;
	int         idle_cycles = 0;
	bit         calm = 1'b0;
	string      slot_word [SLOTS];

	woc_req_if req ();
	woc_res_if res ();

	word_occurrence_counter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	word_occurrence_counter_checker i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.pending  (pending),
		.errors   (errors)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[word_occurrence_counter] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : sink_side
		@(posedge clk iff arst_n);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	task automatic put(input logic [1:0] kind, input logic [6:0] slot, input logic [3:0] pos,
		input logic [7:0] ch, input logic last);
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.slot       <= slot;
		req.position   <= pos;
		req.char_value <= ch;
		req.text_last  <= last;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic load_char(input int s, input int p, input logic [7:0] ch);
		put(REQ_LOAD, 7'(s), 4'(p), ch, 1'($urandom));
	endtask

	task automatic text_char(input logic [7:0] ch, input logic last);
		put(REQ_TEXT, 7'($urandom), 4'($urandom), ch, last);
	endtask

	task automatic read_slot(input int s);
		put(REQ_READ, 7'(s), 4'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic start_text();
		put(REQ_START, 7'($urandom), 4'($urandom), 8'($urandom), 1'($urandom));
	endtask

	task automatic load_query(input int s, input string w);
		for (int i = 0; i < w.len(); i++)
			load_char(s, i, w[i]);
		if (w.len() <= WORD_CHARS)
			load_char(s, w.len(), 8'd0);
		slot_word[s] = w;
	endtask

	// hold requests off until every result is back
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic byte rand_letter();
		return byte'($urandom_range(0, 1) ? 65 + $urandom_range(0, 25)
			: 97 + $urandom_range(0, 25));
	endfunction

	function automatic string rand_word(input int len);
		string w;
		string pool;
		bit narrow;
		w = "";
		pool = "abAB";
		narrow = $urandom_range(0, 1);
		for (int i = 0; i < len; i++) begin
			w = {w, "x"};
			w[i] = narrow ? pool[$urandom_range(0, 3)] : rand_letter();
		end
		return w;
	endfunction

	function automatic logic [7:0] separator();
		int c;
		case ($urandom_range(0, 3))
			0: c = 32;
			1: c = $urandom_range(0, 64);
			2: begin
				c = $urandom_range(0, 10);
				c = (c < 6) ? 91 + c : 117 + c;
			end
			default: c = $urandom_range(128, 255);
		endcase
		return 8'(c);
	endfunction

	function automatic int pick_slot();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, SLOTS - 1) : $urandom_range(0, 15);
	endfunction

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd255;
			3: return 8'($urandom_range(2, 16));
			4: return 8'($urandom);
			default: return 8'(SLOTS);
		endcase
	endfunction

	// mostly loaded query words, some with a flipped case, extended or cut short
	function automatic string pick_word();
		string w;
		int k;
		w = slot_word[$urandom_range(0, 15)];
		if (w.len() == 0 || $urandom_range(0, 3) == 0)
			return rand_word($urandom_range(1, 14));
		case ($urandom_range(0, 5))
			0: begin
				k = $urandom_range(0, w.len() - 1);
				w[k] = w[k] ^ 8'h20;
			end
			1: w = {w, rand_word($urandom_range(1, 3))};
			2: if (w.len() > 1) w = w.substr(0, w.len() - 2);
			default: ;
		endcase
		return w;
	endfunction

	task automatic say_word(input string w, input bit closing);
		bit on_letter;
		on_letter = closing && $urandom_range(0, 1);
		for (int i = 0; i < w.len(); i++)
			text_char(w[i], on_letter && i == w.len() - 1);
		if (!on_letter) begin
			if ($urandom_range(0, 7) == 0)
				text_char(separator(), 1'b0);
			text_char(separator(), closing || $urandom_range(0, 24) == 0);
		end
	endtask

	initial begin : stimulus
		string long_word;
		int words;
		int round;
		bit flood;
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = 8'd0;
		req.valid      = 1'b0;
		req.req_type   = REQ_LOAD;
		req.slot       = 7'd0;
		req.position   = 4'd0;
		req.char_value = 8'd0;
		req.text_last  = 1'b0;
		res.ready      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-letter query, full-length query met by a longer text word, high byte separator
		write_limit(8'(SLOTS));
		load_query(0, "A");
		load_query(SLOTS - 1, "abcdefghi");
		load_char(5, 15, 8'h7A);
		start_text();
		text_char(8'h41, 1'b0);
		text_char(8'hFF, 1'b0);
		long_word = "abcdefghij";
		for (int i = 0; i < long_word.len(); i++)
			text_char(long_word[i], i == long_word.len() - 1);
		read_slot(0);
		read_slot(SLOTS - 1);

		sent = 0;
		round = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
			if (round < 2)
				write_limit(round == 0 ? 8'd255 : 8'd0);
			else if ($urandom_range(0, 2) == 0)
				write_limit(pick_limit());
			repeat ($urandom_range(0, 4)) begin
				case ($urandom_range(0, 9))
					0: load_char(pick_slot(), $urandom_range(0, 15), 8'($urandom));
					1: load_query(pick_slot(), rand_word(WORD_CHARS + 1));
					default: load_query(pick_slot(), rand_word($urandom_range(1, WORD_CHARS)));
				endcase
			end
			if ($urandom_range(0, 5) != 0)
				start_text();
			flood = (round == 3 || $urandom_range(0, 19) == 0);
			words = flood ? MAX_TEXT_WORDS + 8 : $urandom_range(3, 25);
			if ($urandom_range(0, 3) == 0)
				text_char(separator(), 1'b0);
			for (int i = 0; i < words; i++) begin
				if ($urandom_range(0, 14) == 0)
					load_query(pick_slot(), rand_word($urandom_range(1, WORD_CHARS)));
				say_word(flood ? rand_word(1) : pick_word(),
					i == words - 1 && $urandom_range(0, 1));
			end
			repeat ($urandom_range(1, 6)) read_slot(pick_slot());
			round++;
		end

		drain();
		repeat (SLOTS + 16) @(posedge clk);
		if (errors == 0) begin
			$display("[word_occurrence_counter] OK");
		end else begin
			$display("[word_occurrence_counter] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/woc_pkg.sv
hdl/woc_if.sv
hdl/woc_front.sv
hdl/woc_cell.sv
hdl/word_occurrence_counter.sv
hdl/woc_checker.sv
test/word_occurrence_counter_checker.sv
test/word_occurrence_counter_test.sv
